FILE: rtl/agrs_pkg.sv
// agrs_pkg: shared types and constants for the gearbox / engine speed block.
// No dependencies.
package agrs_pkg;
    localparam int unsigned WORD_W = 38;
    localparam logic [20:0] RPM_LO = 21'(700 << 8);
    localparam logic [20:0] RPM_HI = 21'(7600 << 8);
    localparam logic [23:0] TARGET_SAT = 24'hFFFF00;
    localparam logic [11:0] RATIO_FLOOR = 12'd26;
    localparam logic [15:0] SCALE_LO = 16'd3277;
    localparam logic [15:0] SCALE_HI = 16'd22938;
    localparam logic [2:0] CFG_TOP = 3'd0;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TGT   = 7'b0000010,
        ST_STEP  = 7'b0000100,
        ST_SHIFT = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_DRIVE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    function automatic logic [11:0] w_ratio(input logic [WORD_W-1:0] w);
        return w[11:0];
    endfunction
    function automatic logic [12:0] w_up(input logic [WORD_W-1:0] w);
        return w[24:12];
    endfunction
    function automatic logic [12:0] w_down(input logic [WORD_W-1:0] w);
        return w[37:25];
    endfunction
endpackage

FILE: rtl/auto_gearbox_rpm_shift.sv
// auto_gearbox_rpm_shift: top level, sequencer around one shared multiplier.
// Depends on agrs_pkg and agrs_div.
//
// Usage: each tick request on s_axis carries throttle, wheel speed and tick
// length; one result request on m_axis carries drive level, engine rpm and
// gear. cfg_* writes the registers (0 top gear, 1..5 gear words); any
// register write returns the engine to gear 1 and speed 0.
// A sequencer drives one 32x32 multiplier through five products, and the
// drive factor comes from a 26-step restoring divider. s_axis_tready is
// high only while idle with no result pending; one tick at a time, so a
// new tick is not taken while the last one is still being worked. The
// result sits in an output register until m_axis_tready; the next tick is
// accepted once it is taken, so a stalled receiver holds the block.
// Reset: top gear 5, default gear table, gear 1, speed 0, no result pending.
// cfg_ready stays high; writes are meant only while the block is idle.
module auto_gearbox_rpm_shift #(
    parameter int MAX_FORWARD_GEARS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] throttle_cmd, [31:16] road_speed, [47:32] time_step
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] drive_level, [28:16] engine_speed_rpm, [31:29] gear_now
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [37:0] cfg_data
);
    import agrs_pkg::*;
    localparam int GW = $clog2(MAX_FORWARD_GEARS + 1);
    localparam logic [37:0] DEF [5] = '{38'd40286618419, 38'd57065472538,
        38'd63777587571, 38'd70489702669, 38'd80557260015};

    logic [2:0]  top_reg;
    logic [37:0] words_reg [MAX_FORWARD_GEARS+1];
    logic [20:0] spd_reg;
    logic [GW-1:0] gear_reg;
    state_t      st_reg;
    logic [2:0]  sub_reg;
    logic signed [15:0] thr_reg;
    logic [15:0] mag_reg, dt_reg;
    logic [23:0] tgt_reg;
    logic [16:0] gain_reg;
    logic [15:0] scale_reg;
    logic        ovalid_reg;
    logic [31:0] odata_reg;
    logic [31:0] ma, mb;
    logic [63:0] prod_reg;
    logic        div_start, div_done;
    logic [25:0] div_q;
    logic [GW-1:0] top_use;
    logic [37:0] wcur, w1;
    logic [11:0] den;
    logic [23:0] diffm;
    logic        neg;
    logic [15:0] thr_c;
    logic        thr_n;

    agrs_div u_div (.aclk, .aresetn, .start(div_start),
        .dividend({w_ratio(wcur), 14'd0}), .divisor(den),
        .done(div_done), .quotient(div_q));

    always_comb begin
        if (top_reg == 3'd0) top_use = GW'(1);
        else if (32'(top_reg) > MAX_FORWARD_GEARS) top_use = GW'(MAX_FORWARD_GEARS);
        else top_use = GW'(top_reg);
    end
    assign wcur = words_reg[gear_reg];
    assign w1 = words_reg[1];
    assign den = (w_ratio(w1) < RATIO_FLOOR) ? RATIO_FLOOR : w_ratio(w1);
    assign neg = ({3'd0, spd_reg} > tgt_reg);
    assign diffm = neg ? ({3'd0, spd_reg} - tgt_reg) : (tgt_reg - {3'd0, spd_reg});
    assign thr_n = thr_reg[15];
    always_comb begin
        if (thr_reg > 16'sd16384) thr_c = 16'd16384;
        else if (thr_reg < -16'sd16384) thr_c = 16'd16384;
        else thr_c = thr_n ? 16'(-thr_reg) : 16'(thr_reg);
    end

    // shared multiplier operand select, one product per sub-step
    always_comb begin
        ma = '0;
        mb = '0;
        case (sub_reg)
            3'd0: begin ma = {16'd0, mag_reg}; mb = {20'd0, w_ratio(wcur)}; end
            3'd1: begin ma = prod_reg[31:0]; mb = 32'd250; end
            3'd2: begin ma = {17'd0, thr_n ? 15'd0 : thr_reg[14:0]}; mb = 32'd1400; end
            3'd3: begin ma = {8'd0, diffm}; mb = {15'd0, gain_reg}; end
            3'd4, 3'd5: begin ma = {16'd0, thr_c}; mb = {16'd0, scale_reg}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign s_axis_tready = (st_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
    assign cfg_ready = 1'b1;
    assign div_start = (st_reg == ST_SHIFT) && (sub_reg == 3'd1);

    logic [24:0] tsum;
    logic [32:0] tspd;
    logic [20:0] gain10;
    logic [25:0] nsp;
    logic [15:0] dv;
    logic [GW-1:0] gnew;
    assign tsum = {1'b0, tgt_reg} + 25'(prod_reg[31:6]);
    assign tspd = 33'd230400 + {1'b0, prod_reg[39:8]};
    assign gain10 = 21'(dt_reg) * 21'd10;
    assign nsp = neg ? ({5'd0, spd_reg} - {1'b0, prod_reg[40:16]})
                     : ({5'd0, spd_reg} + {1'b0, prod_reg[40:16]});
    assign dv = 16'(prod_reg[29:14]);

    always_comb begin
        gnew = gear_reg;
        if (gear_reg < top_use && spd_reg > {w_up(wcur), 8'd0}) gnew = gear_reg + GW'(1);
        else if (gear_reg > GW'(1) && spd_reg < {w_down(wcur), 8'd0})
            gnew = gear_reg - GW'(1);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
        if (!aresetn) begin
            top_reg <= 3'd5;
            for (int i = 0; i <= MAX_FORWARD_GEARS; i++)
                words_reg[i] <= (i >= 1 && i <= 5) ? DEF[i-1] : '0;
            spd_reg <= '0;
            gear_reg <= GW'(1);
            st_reg <= ST_IDLE;
            sub_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (ovalid_reg && m_axis_tready) ovalid_reg <= 1'b0;
            if (cfg_valid && cfg_index <= 3'd5) begin
                if (cfg_index == CFG_TOP) top_reg <= cfg_data[2:0];
                else if (32'(cfg_index) <= MAX_FORWARD_GEARS)
                    words_reg[cfg_index[GW-1:0]] <= cfg_data;
                spd_reg <= '0;
                gear_reg <= GW'(1);
            end
            case (st_reg)
                ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    thr_reg <= s_axis_tdata[15:0];
                    mag_reg <= s_axis_tdata[31] ? 16'(-s_axis_tdata[31:16])
                                                : s_axis_tdata[31:16];
                    dt_reg <= s_axis_tdata[47:32];
                    if (gear_reg < GW'(1) || gear_reg > top_use) gear_reg <= GW'(1);
                    sub_reg <= 3'd0;
                    st_reg <= ST_TGT;
                end
                ST_TGT: begin
                    // pipeline: issue product, capture it from prod_reg in the next cycle
                    if (sub_reg == 3'd2)
                        tgt_reg <= (tspd > {9'd0, TARGET_SAT}) ? TARGET_SAT : tspd[23:0];
                    if (sub_reg == 3'd3) begin
                        tgt_reg <= (tsum > {1'b0, TARGET_SAT}) ? TARGET_SAT : tsum[23:0];
                        gain_reg <= (gain10 > 21'd65536) ? 17'd65536 : gain10[16:0];
                        // step product reissued once target and gain are settled
                        sub_reg <= 3'd3;
                        st_reg <= ST_STEP;
                    end else begin
                        sub_reg <= sub_reg + 3'd1;
                    end
                end
                ST_STEP: begin
                    if (sub_reg == 3'd4) begin
                        if (neg && ({5'd0, spd_reg} < {1'b0, prod_reg[40:16]}))
                            spd_reg <= RPM_LO;
                        else if (nsp < {5'd0, RPM_LO}) spd_reg <= RPM_LO;
                        else if (nsp > {5'd0, RPM_HI}) spd_reg <= RPM_HI;
                        else spd_reg <= nsp[20:0];
                        sub_reg <= 3'd0;
                        st_reg <= ST_SHIFT;
                    end else begin
                        sub_reg <= sub_reg + 3'd1;
                    end
                end
                ST_SHIFT: begin
                    sub_reg <= sub_reg + 3'd1;
                    if (sub_reg == 3'd0) gear_reg <= gnew;
                    if (sub_reg == 3'd1) st_reg <= ST_DIV;
                end
                ST_DIV: if (div_done) begin
                    scale_reg <= (div_q < 26'(SCALE_LO)) ? SCALE_LO :
                                 (div_q > 26'(SCALE_HI)) ? SCALE_HI : div_q[15:0];
                    sub_reg <= 3'd4;
                    st_reg <= ST_DRIVE;
                end
                ST_DRIVE: begin
                    sub_reg <= 3'd5;
                    if (sub_reg == 3'd5) st_reg <= ST_OUT;
                end
                ST_OUT: begin
                    odata_reg <= {3'(gear_reg), spd_reg[20:8], thr_n ? 16'(-dv) : dv};
                    ovalid_reg <= 1'b1;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    a_gear_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[31:29] != 3'd0)) else $error("gear zero");
    a_rpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> (m_axis_tdata[28:16] >= 13'd700 &&
        m_axis_tdata[28:16] <= 13'd7600)) else $error("rpm out of range");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
endmodule

FILE: rtl/agrs_div.sv
// agrs_div: restoring divider, one quotient bit per cycle (26 / 12 bits).
// Depends on agrs_pkg only for style consistency.
module agrs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [25:0] dividend,
    input  logic [11:0] divisor,
    output logic        done,
    output logic [25:0] quotient
);
    import agrs_pkg::*;
    logic [25:0] q_reg, q_next;
    logic [12:0] r_reg, r_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [11:0] d_reg, d_next;
    logic [12:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        d_next = d_reg;
        done = 1'b0;
        trial = {r_reg[11:0], q_reg[25]};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 5'd26;
            busy_next = 1'b1;
            d_next = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[24:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[24:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
            end
        end else begin
            done = (cnt_reg == 5'd0);
        end
    end

    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= 5'd1;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
